FILE: hdl/four_level_page_table_walker_assert.svh
// Assertion macros used by the page table walker top level.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLPTW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FLPTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/flptw_pkg.sv
// Types, codes and helper functions of the four-level page table walker.
package flptw_pkg;

	localparam int VADDR_BITS    = 48;
	localparam int PADDR_BITS    = 52;
	localparam int ENTRY_BITS    = 64;
	localparam int TABLE_ENTRIES = 'h200;
	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int PAGE_BITS     = 12;
	localparam int FRAME_BITS    = PADDR_BITS - PAGE_BITS;
	localparam int PRESENT_BIT   = 0;
	localparam int LARGE_BIT     = 7;

	localparam logic FUNC_REQUEST  = 1'b0;
	localparam logic FUNC_RESPONSE = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_PRESENT = 2'd1,
		ST_READ_FAULT  = 2'd2,
		ST_UNEXPECTED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		LVL_PML4 = 2'd0,
		LVL_PDPT = 2'd1,
		LVL_PD   = 2'd2,
		LVL_PT   = 2'd3
	} level_t;

	// Command class decided by the front end before the walk state is known.
	typedef enum logic [1:0] {
		CMD_REQUEST = 2'd0,
		CMD_FAULT   = 2'd1,
		CMD_ABSENT  = 2'd2,
		CMD_ENTRY   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic                    func;
		logic [VADDR_BITS-1:0]   virt_addr;
		logic [PADDR_BITS-1:0]   table_base;
		logic [ENTRY_BITS-1:0]   entry_word;
		logic                    read_fault;
	} item_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic [VADDR_BITS-1:0]   virt_addr;
		logic [FRAME_BITS-1:0]   frame;
		logic                    ps_flag;
	} cmd_item_t;

	typedef struct packed {
		logic                    kind;
		logic [PADDR_BITS-1:0]   read_addr;
		logic [PADDR_BITS-1:0]   phys_addr;
		status_t                 status;
		logic                    large_page;
	} result_t;

	function automatic logic [IDX_BITS-1:0] table_index(input logic [VADDR_BITS-1:0] va,
		input level_t lvl);
		logic [IDX_BITS-1:0] idx;
		unique case (lvl)
			LVL_PML4: idx = va[47:39];
			LVL_PDPT: idx = va[38:30];
			LVL_PD:   idx = va[29:21];
			LVL_PT:   idx = va[20:12];
			default:  idx = '0;
		endcase
		return idx;
	endfunction

endpackage

FILE: hdl/flptw_stream_if.sv
// Valid/ready stream interface used for every channel of the walker.
interface flptw_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/flptw_front.sv
// Front end: classifies each incoming beat into a walker command.
module flptw_front (
	flptw_stream_if.sink   items,
	flptw_stream_if.source cmds
);
	flptw_pkg::cmd_item_t cmd_d;

	always_comb begin
		cmd_d.virt_addr = items.data.virt_addr;
		cmd_d.ps_flag   = items.data.entry_word[flptw_pkg::LARGE_BIT];
		if (items.data.func == flptw_pkg::FUNC_REQUEST) begin
			cmd_d.cmd   = flptw_pkg::CMD_REQUEST;
			cmd_d.frame = items.data.table_base[flptw_pkg::PADDR_BITS-1:flptw_pkg::PAGE_BITS];
		end else begin
			cmd_d.frame = items.data.entry_word[flptw_pkg::PADDR_BITS-1:flptw_pkg::PAGE_BITS];
			// A read fault wins over whatever the entry word holds.
			if (items.data.read_fault) begin
				cmd_d.cmd = flptw_pkg::CMD_FAULT;
			end else if (!items.data.entry_word[flptw_pkg::PRESENT_BIT]) begin
				cmd_d.cmd = flptw_pkg::CMD_ABSENT;
			end else begin
				cmd_d.cmd = flptw_pkg::CMD_ENTRY;
			end
		end
	end

	assign cmds.valid  = items.valid;
	assign cmds.data   = cmd_d;
	assign items.ready = cmds.ready;
endmodule

FILE: hdl/flptw_queue.sv
// Short command queue between the front end and the walk engine.
module flptw_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	flptw_stream_if.sink   push_if,
	flptw_stream_if.source pop_if
);
	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	flptw_pkg::cmd_item_t slots_q [DEPTH];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [CntW-1:0]      count_q;
	logic                 push;
	logic                 pop;

	assign push_if.ready = (count_q != CntW'(DEPTH));
	assign pop_if.valid  = (count_q != '0);
	assign pop_if.data   = slots_q[rd_ptr_q];
	assign push          = push_if.valid && push_if.ready;
	assign pop           = pop_if.valid && pop_if.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CntW'(push) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_if.data;
		end
	end
endmodule

FILE: hdl/flptw_back.sv
// Walk engine: holds the walk state, decodes one command per beat and registers the result.
module flptw_back #(
	parameter int PHYS_ADDR_BITS = 52
) (
	input  logic           clk,
	input  logic           arst_n,
	flptw_stream_if.sink   cmds,
	flptw_stream_if.source results
);
	localparam int PaW = flptw_pkg::PADDR_BITS;
	localparam logic [PaW-1:0] AddrMask = {PaW{1'b1}} >> (PaW - PHYS_ADDR_BITS);

	logic                                busy_q;
	flptw_pkg::level_t                   level_q;
	logic [flptw_pkg::VADDR_BITS-1:0]    vaddr_q;
	logic                                out_valid_q;
	flptw_pkg::result_t                  res_q;

	logic                                busy_d;
	flptw_pkg::level_t                   level_d;
	logic [flptw_pkg::VADDR_BITS-1:0]    vaddr_d;
	flptw_pkg::result_t                  res_d;
	logic                                take;
	flptw_pkg::level_t                   next_level;
	flptw_pkg::cmd_item_t                c;

	assign c          = cmds.data;
	assign take       = cmds.valid && (!out_valid_q || results.ready);
	assign cmds.ready = !out_valid_q || results.ready;
	assign next_level = flptw_pkg::level_t'(level_q + 2'd1);

	always_comb begin
		busy_d           = busy_q;
		level_d          = level_q;
		vaddr_d          = vaddr_q;
		res_d.kind       = flptw_pkg::KIND_DONE;
		res_d.read_addr  = '0;
		res_d.phys_addr  = '0;
		res_d.status     = flptw_pkg::ST_UNEXPECTED;
		res_d.large_page = 1'b0;
		if (c.cmd == flptw_pkg::CMD_REQUEST) begin
			if (!busy_q) begin
				busy_d          = 1'b1;
				level_d         = flptw_pkg::LVL_PML4;
				vaddr_d         = c.virt_addr;
				res_d.kind      = flptw_pkg::KIND_READ;
				res_d.status    = flptw_pkg::ST_OK;
				res_d.read_addr = {c.frame,
					flptw_pkg::table_index(c.virt_addr, flptw_pkg::LVL_PML4), 3'b000} & AddrMask;
			end
		end else if (busy_q) begin
			// Every response below ends the walk unless it points at the next table.
			busy_d  = 1'b0;
			level_d = flptw_pkg::LVL_PML4;
			case (c.cmd)
				flptw_pkg::CMD_FAULT: begin
					res_d.status = flptw_pkg::ST_READ_FAULT;
				end
				flptw_pkg::CMD_ABSENT: begin
					res_d.status = flptw_pkg::ST_NOT_PRESENT;
				end
				default: begin
					res_d.status = flptw_pkg::ST_OK;
					if (level_q == flptw_pkg::LVL_PDPT && c.ps_flag) begin
						res_d.phys_addr  = {c.frame[39:18], vaddr_q[29:0]} & AddrMask;
						res_d.large_page = 1'b1;
					end else if (level_q == flptw_pkg::LVL_PD && c.ps_flag) begin
						res_d.phys_addr  = {c.frame[39:9], vaddr_q[20:0]} & AddrMask;
						res_d.large_page = 1'b1;
					end else if (level_q == flptw_pkg::LVL_PT) begin
						res_d.phys_addr  = {c.frame, vaddr_q[11:0]} & AddrMask;
					end else begin
						busy_d          = 1'b1;
						level_d         = next_level;
						res_d.kind      = flptw_pkg::KIND_READ;
						res_d.read_addr = {c.frame,
							flptw_pkg::table_index(vaddr_q, next_level), 3'b000} & AddrMask;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			level_q     <= flptw_pkg::LVL_PML4;
			vaddr_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q      <= busy_d;
				level_q     <= level_d;
				vaddr_q     <= vaddr_d;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = res_q;
endmodule

FILE: hdl/four_level_page_table_walker.sv
// A result passes through the command queue and then the walk engine's output register.
// Throughput: one beat per cycle while results.ready is high; the walk engine decodes a response
// combinationally, and the command queue lets input beats keep arriving, until it is full, while a result waits.
// Memory latency between a read request and its response sets the length of a walk.
// Reset (arst_n low, asynchronous) empties the queue and output register and leaves
// the walker idle at the top level with a zero held address.
`include "four_level_page_table_walker_assert.svh"

module four_level_page_table_walker #(
	parameter int PHYS_ADDR_BITS = 52,
	parameter int QUEUE_DEPTH    = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	flptw_stream_if.sink   items,
	flptw_stream_if.source results
);
	localparam int PaW = flptw_pkg::PADDR_BITS;
	localparam logic [PaW-1:0] AddrMask = {PaW{1'b1}} >> (PaW - PHYS_ADDR_BITS);

	flptw_stream_if #(.data_t(flptw_pkg::cmd_item_t)) front_cmds ();
	flptw_stream_if #(.data_t(flptw_pkg::cmd_item_t)) back_cmds ();

	flptw_front u_front (
		.items (items),
		.cmds  (front_cmds)
	);

	flptw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_if (front_cmds),
		.pop_if  (back_cmds)
	);

	flptw_back #(
		.PHYS_ADDR_BITS (PHYS_ADDR_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmds    (back_cmds),
		.results (results)
	);

	`FLPTW_ASSERT_NEXT(a_cmd_gives_result, clk, arst_n, back_cmds.valid && back_cmds.ready, results.valid, "decoded command produced no result beat")
	`FLPTW_ASSERT_IMPL(a_read_is_ok, clk, arst_n, results.valid && results.data.kind == flptw_pkg::KIND_READ, results.data.status == flptw_pkg::ST_OK && results.data.phys_addr == '0 && !results.data.large_page, "read request beat carries done fields")
	`FLPTW_ASSERT_IMPL(a_done_no_read, clk, arst_n, results.valid && results.data.kind == flptw_pkg::KIND_DONE, results.data.read_addr == '0, "finished walk carries a read address")
	`FLPTW_ASSERT_IMPL(a_addr_in_range, clk, arst_n, results.valid, (results.data.read_addr & ~AddrMask) == '0 && (results.data.phys_addr & ~AddrMask) == '0, "address bits above the physical width are set")
endmodule
